FILE: rtl/ohist_pkg.sv
// Shared constants and types of the orientation histogram unit.
package ohist_pkg;

  localparam int unsigned NumBins    = 9;
  localparam int unsigned MagW       = 16;
  localparam int unsigned AngW       = 16;
  localparam int unsigned SumW       = 22;
  localparam int unsigned FracW      = 12;
  localparam int unsigned BinW       = 4;
  localparam int unsigned FoldW      = 15;
  localparam int unsigned QuoW       = 16;
  localparam int unsigned QueueDepth = 4;

  // Pi in Q3.13 radians.
  localparam int unsigned AnglePi    = 25736;
  // Nine bins in Q.12, and half a bin.
  localparam int unsigned BinSpan    = 36864;
  localparam int unsigned HalfBin    = 2048;
  // floor(BinSpan * 2^RecipShift / AnglePi).
  localparam int unsigned RecipM     = 93873;
  localparam int unsigned RecipShift = 16;

  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};
  localparam logic [BinW-1:0] LastBin = BinW'(NumBins - 1);

  typedef logic [BinW-1:0] bin_idx_t;
  typedef logic [SumW-1:0] sum_t;
  typedef sum_t [NumBins-1:0] hist_t;

  typedef struct packed {
    bin_idx_t        lo_bin;
    logic [MagW-1:0] lo_part;
    logic [MagW-1:0] hi_part;
    logic            cell_end;
  } vote_t;

  typedef struct packed {
    logic pop;
    logic emit;
  } back_stat_t;

endpackage

FILE: rtl/ohist_if.sv
// Stream interfaces for pixel words and histogram words.
interface ohist_in_if;
  logic                                valid;
  logic                                ready;
  logic [ohist_pkg::MagW-1:0]          magnitude;
  logic signed [ohist_pkg::AngW-1:0]   orientation;
  logic                                cell_end;

  modport source (output valid, magnitude, orientation, cell_end, input ready);
  modport sink (input valid, magnitude, orientation, cell_end, output ready);
endinterface

interface ohist_out_if;
  logic                       valid;
  logic                       ready;
  logic [ohist_pkg::SumW-1:0] bin_0;
  logic [ohist_pkg::SumW-1:0] bin_1;
  logic [ohist_pkg::SumW-1:0] bin_2;
  logic [ohist_pkg::SumW-1:0] bin_3;
  logic [ohist_pkg::SumW-1:0] bin_4;
  logic [ohist_pkg::SumW-1:0] bin_5;
  logic [ohist_pkg::SumW-1:0] bin_6;
  logic [ohist_pkg::SumW-1:0] bin_7;
  logic [ohist_pkg::SumW-1:0] bin_8;

  modport source (output valid, bin_0, bin_1, bin_2, bin_3, bin_4, bin_5, bin_6, bin_7,
                  bin_8, input ready);
  modport sink (input valid, bin_0, bin_1, bin_2, bin_3, bin_4, bin_5, bin_6, bin_7,
                bin_8, output ready);
endinterface

FILE: rtl/ohist_front.sv
// Front pipeline: folds the angle, finds the bin pair and splits the magnitude.
module ohist_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  ohist_in_if.sink          pix_i,
  output logic              vote_valid_o,
  input  logic              vote_ready_i,
  output ohist_pkg::vote_t  vote_o
);

  logic signed [ohist_pkg::AngW:0] ang_ext;
  logic signed [ohist_pkg::AngW:0] ang_add;
  logic [ohist_pkg::FoldW-1:0]     ang_fold;

  logic en1, en2, en3, en4;
  logic v1_q, v2_q, v3_q, v4_q;

  logic [ohist_pkg::FoldW-1:0] ang1_q, ang2_q;
  logic [ohist_pkg::MagW-1:0]  mag1_q, mag2_q, mag3_q;
  logic                        end1_q, end2_q, end3_q;
  logic [ohist_pkg::QuoW-1:0]  quo2_q;
  ohist_pkg::bin_idx_t         bin3_q;
  logic [ohist_pkg::FracW-1:0] frac3_q;
  ohist_pkg::vote_t            vote4_q;

  logic [31:0]                 recip_prod;
  logic [30:0]                 num_scaled;
  logic [30:0]                 quo_scaled;
  logic [30:0]                 rem;
  logic [16:0]                 quo_fix;
  logic [16:0]                 shifted;
  logic [16:0]                 wrapped;
  logic [27:0]                 split_prod;
  logic [ohist_pkg::MagW-1:0]  hi_part;

  // Fold negative angles by pi, then clamp to 0..pi.
  always_comb begin
    ang_ext = {pix_i.orientation[ohist_pkg::AngW-1], pix_i.orientation};
    ang_add = ang_ext;
    if (ang_ext < 0) begin
      ang_add = ang_ext + (ohist_pkg::AngW+1)'(ohist_pkg::AnglePi);
    end
    if (ang_add < 0) begin
      ang_fold = '0;
    end else if (ang_add > (ohist_pkg::AngW+1)'(ohist_pkg::AnglePi)) begin
      ang_fold = ohist_pkg::FoldW'(ohist_pkg::AnglePi);
    end else begin
      ang_fold = ang_add[ohist_pkg::FoldW-1:0];
    end
  end

  assign en4 = !v4_q || vote_ready_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign pix_i.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= pix_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // The reciprocal estimate is at most one below the true quotient.
  always_comb begin
    recip_prod = 32'(ang1_q) * 32'(ohist_pkg::RecipM);
    num_scaled = 31'(ang2_q) * 31'(ohist_pkg::BinSpan);
    quo_scaled = 31'(quo2_q) * 31'(ohist_pkg::AnglePi);
    rem        = num_scaled - quo_scaled;
    quo_fix    = 17'(quo2_q) + 17'(rem >= 31'(ohist_pkg::AnglePi));
    shifted    = quo_fix + 17'(ohist_pkg::BinSpan - ohist_pkg::HalfBin);
    if (shifted >= 17'(ohist_pkg::BinSpan)) begin
      wrapped = shifted - 17'(ohist_pkg::BinSpan);
    end else begin
      wrapped = shifted;
    end
    split_prod = 28'(mag3_q) * 28'(frac3_q);
    hi_part    = split_prod[ohist_pkg::FracW +: ohist_pkg::MagW];
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      ang1_q <= ang_fold;
      mag1_q <= pix_i.magnitude;
      end1_q <= pix_i.cell_end;
    end
    if (en2) begin
      ang2_q <= ang1_q;
      quo2_q <= recip_prod[ohist_pkg::RecipShift +: ohist_pkg::QuoW];
      mag2_q <= mag1_q;
      end2_q <= end1_q;
    end
    if (en3) begin
      bin3_q  <= wrapped[ohist_pkg::FracW +: ohist_pkg::BinW];
      frac3_q <= wrapped[ohist_pkg::FracW-1:0];
      mag3_q  <= mag2_q;
      end3_q  <= end2_q;
    end
    if (en4) begin
      vote4_q.lo_bin   <= bin3_q;
      vote4_q.hi_part  <= hi_part;
      vote4_q.lo_part  <= mag3_q - hi_part;
      vote4_q.cell_end <= end3_q;
    end
  end

  assign vote_valid_o = v4_q;
  assign vote_o       = vote4_q;

endmodule

FILE: rtl/ohist_queue.sv
// Small FIFO of votes between the front pipeline and the accumulators.
module ohist_queue (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  push_valid_i,
  output logic                                  push_ready_o,
  input  ohist_pkg::vote_t                      push_data_i,
  output logic                                  pop_valid_o,
  input  logic                                  pop_ready_i,
  output ohist_pkg::vote_t                      pop_data_o,
  output logic [$clog2(ohist_pkg::QueueDepth):0] count_o
);

  localparam int unsigned PtrW = $clog2(ohist_pkg::QueueDepth);

  ohist_pkg::vote_t entries_q [ohist_pkg::QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]    count_q;
  logic             push, pop;

  assign push_ready_o = count_q != (PtrW+1)'(ohist_pkg::QueueDepth);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = entries_q[rd_ptr_q];
  assign count_o      = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) entries_q[wr_ptr_q] <= push_data_i;
  end

endmodule

FILE: rtl/ohist_back.sv
// Back end: saturating bin accumulators, cell pixel count and result register.
module ohist_back #(
  parameter int unsigned MAX_CELL_PIXELS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  pop_valid_i,
  output logic                  pop_ready_o,
  input  ohist_pkg::vote_t      pop_data_i,
  ohist_out_if.source           hist_o,
  output ohist_pkg::back_stat_t stat_o
);

  localparam int unsigned CntW = $clog2(MAX_CELL_PIXELS + 1);

  ohist_pkg::hist_t    sums_q, sums_next, bins_q;
  logic [CntW-1:0]     cnt_q, cnt_inc;
  logic                out_v_q;
  ohist_pkg::bin_idx_t hi_bin;
  logic                last_eff, can_emit, pop, emit;
  logic [ohist_pkg::MagW-1:0] part;
  logic [ohist_pkg::SumW:0]   total;

  always_comb begin
    if (pop_data_i.lo_bin == ohist_pkg::LastBin) begin
      hi_bin = '0;
    end else begin
      hi_bin = pop_data_i.lo_bin + 1'b1;
    end
    part  = '0;
    total = '0;
    for (int k = 0; k < ohist_pkg::NumBins; k++) begin
      if (pop_data_i.lo_bin == ohist_pkg::BinW'(k)) begin
        part = pop_data_i.lo_part;
      end else if (hi_bin == ohist_pkg::BinW'(k)) begin
        part = pop_data_i.hi_part;
      end else begin
        part = '0;
      end
      total = {1'b0, sums_q[k]} + (ohist_pkg::SumW+1)'(part);
      sums_next[k] = total[ohist_pkg::SumW] ? ohist_pkg::SumMax
                                            : total[ohist_pkg::SumW-1:0];
    end
  end

  assign cnt_inc     = cnt_q + 1'b1;
  assign last_eff    = pop_data_i.cell_end || (cnt_inc >= CntW'(MAX_CELL_PIXELS));
  assign can_emit    = !out_v_q || hist_o.ready;
  assign pop_ready_o = !last_eff || can_emit;
  assign pop         = pop_valid_i && pop_ready_o;
  assign emit        = pop && last_eff;
  assign stat_o.pop  = pop;
  assign stat_o.emit = emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sums_q  <= '0;
      cnt_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (emit) begin
        sums_q <= '0;
        cnt_q  <= '0;
      end else if (pop) begin
        sums_q <= sums_next;
        cnt_q  <= cnt_inc;
      end
      if (emit) begin
        out_v_q <= 1'b1;
      end else if (hist_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) bins_q <= sums_next;
  end

  assign hist_o.valid = out_v_q;
  assign hist_o.bin_0 = bins_q[0];
  assign hist_o.bin_1 = bins_q[1];
  assign hist_o.bin_2 = bins_q[2];
  assign hist_o.bin_3 = bins_q[3];
  assign hist_o.bin_4 = bins_q[4];
  assign hist_o.bin_5 = bins_q[5];
  assign hist_o.bin_6 = bins_q[6];
  assign hist_o.bin_7 = bins_q[7];
  assign hist_o.bin_8 = bins_q[8];

endmodule

FILE: rtl/hog_orientation_histogram_9bin_unit.sv
// Top level of the nine-bin orientation histogram unit.
//
// Channel   Direction  Word
// pix_i     in         magnitude (Q8.8), orientation (Q3.13 rad), cell_end
// hist_o    out        bin_0 .. bin_8 (Q14.8 sums), one word per cell
//
// One pixel word is accepted per cycle while the vote queue has room; the
// four-stage front pipeline and the accumulator update both run at that rate.
// A cell's sums are registered when its last vote leaves the queue.
// Reset clears the accumulators and the pixel count at once; no clearing pass.
// While a result waits, pixels keep flowing until the queue fills or the next
// cell end or the pixel limit reaches the accumulators.
module hog_orientation_histogram_9bin_unit #(
  parameter int unsigned MAX_CELL_PIXELS = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ohist_in_if.sink     pix_i,
  ohist_out_if.source  hist_o
);

  logic                                   vote_valid, vote_ready;
  ohist_pkg::vote_t                       vote_data;
  logic                                   q_valid, q_ready;
  ohist_pkg::vote_t                       q_data;
  logic [$clog2(ohist_pkg::QueueDepth):0] q_count;
  ohist_pkg::back_stat_t                  back_stat;

  ohist_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pix_i        (pix_i),
    .vote_valid_o (vote_valid),
    .vote_ready_i (vote_ready),
    .vote_o       (vote_data)
  );

  ohist_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (vote_valid),
    .push_ready_o (vote_ready),
    .push_data_i  (vote_data),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_data),
    .count_o      (q_count)
  );

  ohist_back #(
    .MAX_CELL_PIXELS (MAX_CELL_PIXELS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (q_valid),
    .pop_ready_o (q_ready),
    .pop_data_i  (q_data),
    .hist_o      (hist_o),
    .stat_o      (back_stat)
  );

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= ($clog2(ohist_pkg::QueueDepth)+1)'(ohist_pkg::QueueDepth))
    else $error("vote queue count exceeds its depth");

  a_full_no_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_count == ($clog2(ohist_pkg::QueueDepth)+1)'(ohist_pkg::QueueDepth)) |-> !vote_ready)
    else $error("vote queue accepts a word while full");

  a_pop_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.pop |-> q_valid)
    else $error("accumulators take a vote from an empty queue");

  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.emit |=> hist_o.valid)
    else $error("cell end did not load the result register");

endmodule
